[sv/acp_pkg.sv]
// ----------------------------------------------------------------------------
// acp_pkg
// Shared constants and types of the audio chunk pattern permuter.
// ----------------------------------------------------------------------------
package acp_pkg;

    // configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CHUNKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD = 2'd2;

    // register field widths
    localparam int LEN_W    = 13;
    localparam int NUM_W    = 5;
    localparam int NIB_W    = 4;
    localparam int PAT_NIBS = 16;

    // reset values of the registers
    localparam logic [LEN_W-1:0] CHUNK_LENGTH_RST = 13'd1;
    localparam logic [NUM_W-1:0] NUM_CHUNKS_RST   = 5'd1;

    // configuration as seen by the sequencer
    typedef struct packed {
        logic                              settling;
        logic                              restart;
        logic                              cfg_ok;
        logic [LEN_W-1:0]                  chunk_length;
        logic [NUM_W-1:0]                  num_chunks;
        logic [PAT_NIBS-1:0][NIB_W-1:0]    inv_pattern;
    } cfg_state_t;

    // per-word tag carried alongside the bank read
    typedef struct packed {
        logic bypass;
        logic from_a;
    } item_tag_t;

endpackage

[sv/acp_if.sv]
// ----------------------------------------------------------------------------
// acp_in_if / acp_out_if
// Valid/ready channels for sample words in and permuted words out.
// ----------------------------------------------------------------------------
interface acp_in_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
    modport mon    (input valid, input sample_in, input ready);
endinterface

interface acp_out_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           config_error;

    modport source (output valid, output sample_out, output config_error, input ready);
    modport sink   (input valid, input sample_out, input config_error, output ready);
    modport mon    (input valid, input sample_out, input config_error, input ready);
endinterface

[sv/acp_ram.sv]
// ----------------------------------------------------------------------------
// acp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module acp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/acp_cfg.sv]
// ----------------------------------------------------------------------------
// acp_cfg
// Configuration registers, restart detection and registered validity and
// inverse-pattern lookup.
// ----------------------------------------------------------------------------
module acp_cfg import acp_pkg::*; #(
    parameter int BANK_DEPTH = 4096,
    parameter int MAX_CHUNKS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_state_t            cfg
);

    localparam int PROD_W = LEN_W + NUM_W;

    logic [LEN_W-1:0]               chunk_length_reg, chunk_length_next;
    logic [NUM_W-1:0]               num_chunks_reg, num_chunks_next;
    logic [CFG_DATA_W-1:0]          pattern_reg, pattern_next;
    logic                           settle_reg;
    logic                           restart_reg, restart_next;
    logic                           ok_reg, ok_next;
    logic [PAT_NIBS-1:0][NIB_W-1:0] inv_reg, inv_next;

    logic [PROD_W-1:0]              frame_size;
    logic [PAT_NIBS-1:0]            found;
    logic [PAT_NIBS-1:0][NIB_W-1:0] nib;

    // register writes, restart only when length or count really changes
    always_comb
    begin
        chunk_length_next = chunk_length_reg;
        num_chunks_next   = num_chunks_reg;
        pattern_next      = pattern_reg;
        restart_next      = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CHUNK_LENGTH:
                begin
                    chunk_length_next = cfg_wdata[LEN_W-1:0];
                    restart_next      = (cfg_wdata[LEN_W-1:0] != chunk_length_reg);
                end
                REG_NUM_CHUNKS:
                begin
                    num_chunks_next = cfg_wdata[NUM_W-1:0];
                    restart_next    = (cfg_wdata[NUM_W-1:0] != num_chunks_reg);
                end
                REG_PATTERN_WORD:
                begin
                    pattern_next = cfg_wdata;
                end
                default:
                begin
                    pattern_next = pattern_reg;
                end
            endcase
        end
    end

    // validity check and inverse pattern, registered once per cycle
    always_comb
    begin
        nib        = pattern_reg;
        frame_size = PROD_W'(chunk_length_reg) * PROD_W'(num_chunks_reg);
        ok_next    = (chunk_length_reg != '0) && (num_chunks_reg != '0)
                     && (num_chunks_reg <= NUM_W'(MAX_CHUNKS))
                     && (frame_size <= PROD_W'(BANK_DEPTH));
        found      = '0;
        inv_next   = '0;
        for (int j = 0; j < PAT_NIBS; j++)
        begin
            if (NUM_W'(j) < num_chunks_reg)
            begin
                if (NUM_W'(nib[j]) >= num_chunks_reg)
                begin
                    ok_next = 1'b0;
                end
                found[nib[j]]    = 1'b1;
                inv_next[nib[j]] = NIB_W'(j);
            end
        end
        for (int k = 0; k < PAT_NIBS; k++)
        begin
            if ((NUM_W'(k) < num_chunks_reg) && !found[k])
            begin
                ok_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_length_reg <= CHUNK_LENGTH_RST;
            num_chunks_reg   <= NUM_CHUNKS_RST;
            pattern_reg      <= '0;
            settle_reg       <= 1'b0;
            restart_reg      <= 1'b0;
            ok_reg           <= 1'b1;
            inv_reg          <= '0;
        end
        else
        begin
            chunk_length_reg <= chunk_length_next;
            num_chunks_reg   <= num_chunks_next;
            pattern_reg      <= pattern_next;
            settle_reg       <= cfg_we;
            restart_reg      <= restart_next;
            ok_reg           <= ok_next;
            inv_reg          <= inv_next;
        end
    end

    // derived values are registered from the registers and so lag them, settle covers that
    assign cfg.settling     = settle_reg;
    assign cfg.restart      = restart_reg;
    assign cfg.cfg_ok       = ok_reg;
    assign cfg.chunk_length = chunk_length_reg;
    assign cfg.num_chunks   = num_chunks_reg;
    assign cfg.inv_pattern  = inv_reg;

endmodule

[sv/acp_seq.sv]
// ----------------------------------------------------------------------------
// acp_seq
// Frame counters, bank select, bank address generation and the clearing
// sweep that zeroes both banks after reset and after a restart.
// ----------------------------------------------------------------------------
module acp_seq import acp_pkg::*; #(
    parameter int BANK_DEPTH   = 4096,
    parameter int SAMPLE_WIDTH = 24,
    localparam int ADDR_W = $clog2(BANK_DEPTH)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_state_t              cfg,
    input  logic                    go,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    output logic                    busy,
    output logic                    we_a,
    output logic                    we_b,
    output logic [ADDR_W-1:0]       waddr,
    output logic [SAMPLE_WIDTH-1:0] wdata,
    output logic                    re,
    output logic [ADDR_W-1:0]       raddr,
    output item_tag_t               tag
);

    localparam int MUL_W = NIB_W + LEN_W;
    localparam int SUM_W = ((MUL_W > ADDR_W) ? MUL_W : ADDR_W) + 1;
    localparam int CMP_W = ((LEN_W > ADDR_W) ? LEN_W : ADDR_W) + 1;

    logic              clear_active_reg, clear_active_next;
    logic [ADDR_W-1:0] clear_addr_reg, clear_addr_next;
    logic [ADDR_W-1:0] offset_reg, offset_next;
    logic [NIB_W-1:0]  chunk_reg, chunk_next;
    logic [ADDR_W-1:0] rd_pos_reg, rd_pos_next;
    logic              bank_sel_reg, bank_sel_next;

    logic              step;
    logic [NIB_W-1:0]  dest_chunk;
    logic [MUL_W-1:0]  dest_base;
    logic [SUM_W-1:0]  wr_sum;
    logic              offset_last;
    logic              chunk_last;

    assign step = go && cfg.cfg_ok;

    // write address: destination chunk base plus offset
    always_comb
    begin
        dest_chunk  = cfg.inv_pattern[chunk_reg];
        dest_base   = MUL_W'(dest_chunk) * MUL_W'(cfg.chunk_length);
        wr_sum      = SUM_W'(dest_base) + SUM_W'(offset_reg);
        offset_last = (CMP_W'(offset_reg) + CMP_W'(1)) == CMP_W'(cfg.chunk_length);
        chunk_last  = (NUM_W'(chunk_reg) + NUM_W'(1)) == cfg.num_chunks;
    end

    // counters and clearing sweep
    always_comb
    begin
        clear_active_next = clear_active_reg;
        clear_addr_next   = clear_addr_reg;
        offset_next       = offset_reg;
        chunk_next        = chunk_reg;
        rd_pos_next       = rd_pos_reg;
        bank_sel_next     = bank_sel_reg;
        if (cfg.restart)
        begin
            clear_active_next = 1'b1;
            clear_addr_next   = '0;
            offset_next       = '0;
            chunk_next        = '0;
            rd_pos_next       = '0;
        end
        else if (clear_active_reg)
        begin
            clear_addr_next = clear_addr_reg + ADDR_W'(1);
            if (clear_addr_reg == ADDR_W'(BANK_DEPTH - 1))
            begin
                clear_active_next = 1'b0;
            end
        end
        else if (step)
        begin
            rd_pos_next = rd_pos_reg + ADDR_W'(1);
            offset_next = offset_reg + ADDR_W'(1);
            if (offset_last)
            begin
                offset_next = '0;
                chunk_next  = chunk_reg + NIB_W'(1);
                if (chunk_last)
                begin
                    chunk_next    = '0;
                    rd_pos_next   = '0;
                    bank_sel_next = !bank_sel_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            offset_reg       <= '0;
            chunk_reg        <= '0;
            rd_pos_reg       <= '0;
            bank_sel_reg     <= 1'b0;
        end
        else
        begin
            clear_active_reg <= clear_active_next;
            clear_addr_reg   <= clear_addr_next;
            offset_reg       <= offset_next;
            chunk_reg        <= chunk_next;
            rd_pos_reg       <= rd_pos_next;
            bank_sel_reg     <= bank_sel_next;
        end
    end

    // bank port drive: sweep writes zeros into both banks
    assign busy  = clear_active_reg;
    assign we_a  = clear_active_reg || (step && !bank_sel_reg);
    assign we_b  = clear_active_reg || (step && bank_sel_reg);
    assign waddr = clear_active_reg ? clear_addr_reg : wr_sum[ADDR_W-1:0];
    assign wdata = clear_active_reg ? '0 : sample;
    assign re    = step;
    assign raddr = rd_pos_reg;

    assign tag.bypass = !cfg.cfg_ok;
    assign tag.from_a = bank_sel_reg;

endmodule

[sv/acp_out_buf.sv]
// ----------------------------------------------------------------------------
// acp_out_buf
// Read-data stage and small output queue that decouples the receiver's
// stalls from the bank pipeline.
// ----------------------------------------------------------------------------
module acp_out_buf import acp_pkg::*; #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    go,
    input  item_tag_t               tag,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    input  logic [SAMPLE_WIDTH-1:0] q_a,
    input  logic [SAMPLE_WIDTH-1:0] q_b,
    output logic                    space,
    acp_out_if.source               result_ch
);

    localparam int Q_DEPTH = 4;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = PTR_W + 1;
    localparam int ENT_W   = SAMPLE_WIDTH + 1;

    logic                    s1_valid_reg;
    item_tag_t               s1_tag_reg;
    logic [SAMPLE_WIDTH-1:0] s1_sample_reg;

    logic [ENT_W-1:0]        q_mem_reg [Q_DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]        count_reg, count_next;

    logic [SAMPLE_WIDTH-1:0] s1_data;
    logic                    pop;
    logic [CNT_W-1:0]        total;

    // word leaving the bank read stage
    assign s1_data = s1_tag_reg.bypass ? s1_sample_reg
                   : (s1_tag_reg.from_a ? q_a : q_b);
    assign pop     = result_ch.valid && result_ch.ready;
    assign total   = count_reg + CNT_W'(s1_valid_reg);
    assign space   = (total < CNT_W'(Q_DEPTH));

    // queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(s1_valid_reg);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(s1_valid_reg) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= go;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            s1_tag_reg    <= tag;
            s1_sample_reg <= sample;
        end
        if (s1_valid_reg)
        begin
            q_mem_reg[wr_ptr_reg] <= {s1_data, s1_tag_reg.bypass};
        end
    end

    assign result_ch.valid        = (count_reg != '0);
    assign result_ch.sample_out   = q_mem_reg[rd_ptr_reg][ENT_W-1:1];
    assign result_ch.config_error = q_mem_reg[rd_ptr_reg][0];

endmodule

[sv/audio_chunk_pattern_permuter.sv]
// ----------------------------------------------------------------------------
// audio_chunk_pattern_permuter
// Reorders the chunks of each audio frame through two ping-pong banks.
// ----------------------------------------------------------------------------
// sample_ch takes one sample word per cycle while ready is high; result_ch
// gives one word for each accepted word, in order. A frame is num_chunks
// chunks of chunk_length samples; output chunk j carries input chunk
// pattern[j] of the frame before, so the first frame after a restart is
// all zeros. Each accepted word passes the read stage and output queue;
// while ready is high the throughput is one word per cycle, set by one
// write and one read port per bank (bank a and bank b are separate memories).
// Invalid configuration passes the input through with config_error set.
// After reset, and after a write that changes chunk_length or num_chunks,
// a sweep of every bank address zeroes both banks with sample_ch.ready low.
// Any configuration write holds ready low for one cycle while the pattern
// check settles. A stalled receiver is absorbed by a four-word output
// queue; ready drops once the queued words plus the word in the read
// stage reach four.
// Configuration writes go through cfg_we, cfg_index and cfg_wdata; the user
// must make them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module audio_chunk_pattern_permuter import acp_pkg::*; #(
    parameter int BANK_DEPTH   = 4096,
    parameter int MAX_CHUNKS   = 16,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    acp_in_if.sink                sample_ch,
    acp_out_if.source             result_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int ADDR_W = $clog2(BANK_DEPTH);

    cfg_state_t              cfg;
    item_tag_t               tag;
    logic                    go;
    logic                    busy;
    logic                    space;
    logic                    we_a, we_b, re;
    logic [ADDR_W-1:0]       waddr, raddr;
    logic [SAMPLE_WIDTH-1:0] wdata, q_a, q_b;
    logic [SAMPLE_WIDTH-1:0] sample;

    // input handshake
    assign sample          = sample_ch.sample_in;
    assign sample_ch.ready = space && !busy && !cfg.settling;
    assign go              = sample_ch.valid && sample_ch.ready;

    // configuration registers
    acp_cfg #(
        .BANK_DEPTH (BANK_DEPTH),
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // frame sequencer
    acp_seq #(
        .BANK_DEPTH   (BANK_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .go     (go),
        .sample (sample),
        .busy   (busy),
        .we_a   (we_a),
        .we_b   (we_b),
        .waddr  (waddr),
        .wdata  (wdata),
        .re     (re),
        .raddr  (raddr),
        .tag    (tag)
    );

    // ping-pong banks
    acp_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (BANK_DEPTH)
    ) u_bank_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (q_a)
    );

    acp_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (BANK_DEPTH)
    ) u_bank_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (q_b)
    );

    // read stage and output queue
    acp_out_buf #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .tag       (tag),
        .sample    (sample),
        .q_a       (q_a),
        .q_b       (q_b),
        .space     (space),
        .result_ch (result_ch)
    );

endmodule

[sv/acp_check.sv]
// ----------------------------------------------------------------------------
// acp_check
// Port-level checks of the chunk permuter, bound to the top level.
// ----------------------------------------------------------------------------
module acp_check import acp_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    acp_in_if.sink               sample_ch,
    acp_out_if.source            result_ch,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_wdata
);

    // a configuration write blocks new words for the settle cycle
    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !sample_ch.ready)
        else $error("sample word accepted right after a configuration write");

    // once an accepted word has passed the read stage into the queue, the output is valid
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_ch.valid && sample_ch.ready) |-> ##2 result_ch.valid)
        else $error("accepted word not presented on the output in time");

    // with a draining receiver the input never drops ready on its own
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_ch.ready && result_ch.ready && !cfg_we) |=> sample_ch.ready)
        else $error("input ready dropped while the output drains");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && !result_ch.ready) |=>
            (result_ch.valid && $stable(result_ch.sample_out)
             && $stable(result_ch.config_error)))
        else $error("stalled output word changed");

    // index and data only matter together with the write enable
    logic unused_cfg;
    assign unused_cfg = ^{cfg_index, cfg_wdata, sample_ch.sample_in};

endmodule

bind audio_chunk_pattern_permuter acp_check u_acp_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_ch (sample_ch),
    .result_ch (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
);
